[rtl/core/cfpw_pkg.sv]
package cfpw_pkg;

    // Field widths of the two channels and of one cache entry.
    localparam int VA_W   = 48;
    localparam int ADDR_W = 52;
    localparam int DATA_W = 64;

    // Page table layout.
    localparam int PAGE_SHIFT    = 12;
    localparam int ENTRY_SHIFT   = 3;
    localparam int IDX_W         = 9;
    localparam int TOP_SHIFT     = 39;
    localparam int NUM_LEVELS    = 4;
    localparam int LEVEL_W       = 2;
    localparam int LEVEL_ENTRIES = 512;

    // The four level caches share one memory, addressed by {level, index}.
    localparam int CACHE_IDX_W = LEVEL_W + IDX_W;
    localparam int CACHE_DEPTH = NUM_LEVELS * LEVEL_ENTRIES;

    localparam logic CMD_XLATE = 1'b0;
    localparam logic CMD_RESP  = 1'b1;
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] table_base;
        logic [VA_W-1:0]   virt_addr;
        logic [DATA_W-1:0] read_data;
    } in_item_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] read_address;
        logic [ADDR_W-1:0] physical_address;
        logic              fault;
    } out_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] tag;
        logic [DATA_W-1:0] value;
    } cache_entry_t;

    typedef struct packed {
        logic                   rd_en;
        logic [CACHE_IDX_W-1:0] rd_index;
        logic                   wr_en;
        logic [CACHE_IDX_W-1:0] wr_index;
        cache_entry_t           wr_entry;
    } cache_port_t;

endpackage

[rtl/core/cfpw_cache_mem.sv]
module cfpw_cache_mem (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfpw_pkg::cache_port_t port,
    output cfpw_pkg::cache_entry_t rd_entry,
    output logic                  busy
);
    import cfpw_pkg::*;

    cache_entry_t mem [CACHE_DEPTH];

    logic                   busy_reg;
    logic [CACHE_IDX_W-1:0] clr_idx_reg;

    // After reset every entry is swept to zero, one per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_idx_reg <= '0;
        end
        else if (busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == CACHE_IDX_W'(CACHE_DEPTH - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (port.wr_en)
        begin
            mem[port.wr_index] <= port.wr_entry;
        end
        if (port.rd_en)
        begin
            rd_entry <= mem[port.rd_index];
        end
    end

    assign busy = busy_reg;

endmodule

[rtl/core/cfpw_step_unit.sv]
module cfpw_step_unit #(
    parameter int FRAME_BITS = 36,
    parameter int PHYS_BITS  = 52
) (
    input  logic [PHYS_BITS-1:0]        base,
    input  logic [cfpw_pkg::IDX_W-1:0]  index,
    input  logic [cfpw_pkg::ADDR_W-1:0] tag,
    input  logic [cfpw_pkg::DATA_W-1:0] value,
    output logic [PHYS_BITS-1:0]        entry_addr,
    output logic                        hit,
    output logic [PHYS_BITS-1:0]        frame_addr
);
    import cfpw_pkg::*;

    logic [DATA_W-1:0] frame_full;

    // Entry address wraps at the physical address width.
    assign entry_addr = base + PHYS_BITS'({index, {ENTRY_SHIFT{1'b0}}});
    assign hit        = (tag == ADDR_W'(entry_addr)) && value[0];

    assign frame_full = DATA_W'(value[PAGE_SHIFT +: FRAME_BITS]) << PAGE_SHIFT;
    assign frame_addr = frame_full[PHYS_BITS-1:0];

endmodule

[rtl/core/cached_four_level_page_walker.sv]
// Four-level page-table walker with one 512-entry cache per level. A beat with
// cmd 0 starts a walk of virt_addr from table_base; a beat with cmd 1 is
// the memory's answer to the last read request and is dropped if no walk waits.
// Each result beat is either a read request (kind 0, read_address) or the end
// of a walk (kind 1, physical_address, fault). Each level uses the shared cache
// port in two steps: a read of the entry, then an add and compare that writes
// the entry back on a miss. A beat is taken only while the walker is idle, so a
// new beat waits until the last result is loaded. A response that lets the walk
// go on resumes with the lookup of the next level. A new request during a wait
// for a response drops the old walk. After reset the cache memory is swept to
// zero, and no beat is accepted until the sweep ends.
module cached_four_level_page_walker #(
    parameter int FRAME_BITS = 36,
    parameter int PHYS_BITS  = 52
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  cfpw_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output cfpw_pkg::out_item_t result
);
    import cfpw_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_CMP,
        S_RESP
    } state_t;

    localparam logic [LEVEL_W-1:0] LAST_LEVEL = LEVEL_W'(NUM_LEVELS - 1);

    state_t               state_reg;
    logic [LEVEL_W-1:0]   lv_reg;
    logic                 waiting_reg;
    logic [VA_W-1:0]      va_reg;
    logic [PHYS_BITS-1:0] base_reg;
    logic [PHYS_BITS-1:0] tag_reg;
    logic [DATA_W-1:0]    resp_reg;
    out_item_t            out_reg;
    logic                 out_valid_reg;

    cache_port_t          cport;
    cache_entry_t         rd_entry;
    logic                 clear_busy;

    logic [IDX_W-1:0]     cur_idx;
    logic [DATA_W-1:0]    value_sel;
    logic [PHYS_BITS-1:0] entry_addr;
    logic                 entry_hit;
    logic [PHYS_BITS-1:0] frame_addr;
    logic [PHYS_BITS-1:0] done_pa;
    logic                 slot_free;
    logic                 accept;
    logic                 out_load;

    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input logic [LEVEL_W-1:0] lv);
        return IDX_W'(va >> (TOP_SHIFT - IDX_W * int'(lv)));
    endfunction

    cfpw_cache_mem u_cache (
        .clk      (clk),
        .rst_n    (rst_n),
        .port     (cport),
        .rd_entry (rd_entry),
        .busy     (clear_busy)
    );

    // The one add and compare unit. In the response state it works on the
    // returned entry so that the next level's base comes from the same logic.
    assign cur_idx   = level_index(va_reg, lv_reg);
    assign value_sel = (state_reg == S_RESP) ? resp_reg : rd_entry.value;

    cfpw_step_unit #(
        .FRAME_BITS (FRAME_BITS),
        .PHYS_BITS  (PHYS_BITS)
    ) u_step (
        .base       (base_reg),
        .index      (cur_idx),
        .tag        (rd_entry.tag),
        .value      (value_sel),
        .entry_addr (entry_addr),
        .hit        (entry_hit),
        .frame_addr (frame_addr)
    );

    // The frame base has its low twelve bits clear, so the offset is an OR.
    assign done_pa    = frame_addr | PHYS_BITS'(va_reg[PAGE_SHIFT-1:0]);
    assign slot_free  = !out_valid_reg || result_ready;
    assign item_ready = (state_reg == S_IDLE) && !clear_busy;
    assign accept     = item_valid && item_ready;

    // A result beat is loaded whenever a compare or a response ends the step
    // and the output register is free to take it.
    assign out_load = slot_free &&
                      (((state_reg == S_CMP) && !(entry_hit && lv_reg != LAST_LEVEL)) ||
                       ((state_reg == S_RESP) && !(resp_reg[0] && lv_reg != LAST_LEVEL)));

    // A miss stores the new tag but keeps the old value, as the entry is only
    // refilled by the response. The write waits until the result beat can go.
    always_comb
    begin
        cport          = '0;
        cport.rd_en    = (state_reg == S_LOOK);
        cport.rd_index = {lv_reg, cur_idx};
        cport.wr_index = {lv_reg, cur_idx};
        if (state_reg == S_CMP && !entry_hit && slot_free)
        begin
            cport.wr_en          = 1'b1;
            cport.wr_entry.tag   = ADDR_W'(entry_addr);
            cport.wr_entry.value = rd_entry.value;
        end
        else if (state_reg == S_RESP &&
                 (slot_free || (resp_reg[0] && lv_reg != LAST_LEVEL)))
        begin
            cport.wr_en          = 1'b1;
            cport.wr_entry.tag   = ADDR_W'(tag_reg);
            cport.wr_entry.value = resp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lv_reg        <= '0;
            waiting_reg   <= 1'b0;
            va_reg        <= '0;
            base_reg      <= '0;
            tag_reg       <= '0;
            resp_reg      <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (item.cmd == CMD_XLATE)
                        begin
                            va_reg      <= item.virt_addr;
                            base_reg    <= item.table_base[PHYS_BITS-1:0];
                            lv_reg      <= '0;
                            waiting_reg <= 1'b0;
                            state_reg   <= S_LOOK;
                        end
                        else if (waiting_reg)
                        begin
                            resp_reg  <= item.read_data;
                            state_reg <= S_RESP;
                        end
                    end
                end
                S_LOOK:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (entry_hit && lv_reg != LAST_LEVEL)
                    begin
                        base_reg  <= frame_addr;
                        lv_reg    <= lv_reg + 1'b1;
                        state_reg <= S_LOOK;
                    end
                    else if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                        if (entry_hit)
                        begin
                            out_reg.kind             <= KIND_DONE;
                            out_reg.read_address     <= '0;
                            out_reg.physical_address <= ADDR_W'(done_pa);
                            out_reg.fault            <= 1'b0;
                            waiting_reg              <= 1'b0;
                        end
                        else
                        begin
                            out_reg.kind             <= KIND_READ;
                            out_reg.read_address     <= ADDR_W'(entry_addr);
                            out_reg.physical_address <= '0;
                            out_reg.fault            <= 1'b0;
                            tag_reg                  <= entry_addr;
                            waiting_reg              <= 1'b1;
                        end
                    end
                end
                S_RESP:
                begin
                    if (resp_reg[0] && lv_reg != LAST_LEVEL)
                    begin
                        base_reg    <= frame_addr;
                        lv_reg      <= lv_reg + 1'b1;
                        waiting_reg <= 1'b0;
                        state_reg   <= S_LOOK;
                    end
                    else if (slot_free)
                    begin
                        out_reg.kind             <= KIND_DONE;
                        out_reg.read_address     <= '0;
                        out_reg.physical_address <= resp_reg[0] ? ADDR_W'(done_pa) : '0;
                        out_reg.fault            <= !resp_reg[0];
                        waiting_reg              <= 1'b0;
                        state_reg                <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTH
    // No beat is taken while the cache memory is still being cleared.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !item_ready)
        else $error("beat accepted during cache clearing");

    // The compare always follows a read of the cache or a stall on itself.
    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> ($past(state_reg) == S_LOOK || $past(state_reg) == S_CMP))
        else $error("compare without a fresh cache read");

    // A miss that is sent out leaves the walker waiting for the response.
    a_miss_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP && !entry_hit && slot_free) |=> waiting_reg)
        else $error("read request issued without waiting for response");

    // A read request never carries a fault or a translated address.
    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == KIND_READ) |->
        (!result.fault && result.physical_address == '0))
        else $error("read request carries result fields");
`endif

endmodule
